// ===== hw/rtl/cfcb_pkg.sv =====
// Shared types and constants of the CRC-framed chunk builder.
package cfcb_pkg;

   // Field widths
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned LEN_W     = 6;
   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned CRC_W     = 16;
   localparam int unsigned TOTAL_W   = 7;
   localparam int unsigned CHUNK_W   = 6;
   localparam int unsigned INDEX_W   = 7;
   localparam int unsigned STEP_W    = 3;
   localparam int unsigned RESCNT_W  = 5;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_TDATA_W = 32;

   // Frame constants
   localparam logic [CRC_W-1:0]   CRC_INIT       = 16'hFFFF;
   localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = 7'd8;     // header 5, tail 3
   localparam logic [TOTAL_W-1:0] CHUNK_MAX      = 7'd64;    // size used when register is zero
   localparam logic [BYTE_W-1:0]  LABEL_BASE     = 8'h40;    // 'A' minus one
   localparam logic [STEP_W-1:0]  DIV_LAST_STEP  = 3'd6;     // seven quotient bits
   localparam logic [STEP_W-1:0]  CRC_LAST_STEP  = 3'd7;     // eight bits per byte

   // Configuration reset values
   localparam logic [BYTE_W-1:0]  START_BYTE_RST = 8'h02;
   localparam logic [BYTE_W-1:0]  END_BYTE_RST   = 8'h03;
   localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RST = 6'd19;
   localparam logic [CRC_W-1:0]   CRC_POLY_RST   = 16'h1021;

   // Request opcodes
   typedef enum logic {
      OP_START = 1'b0,
      OP_DATA  = 1'b1
   } opcode_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_BYTE = 2'd0,
      CSR_END_BYTE   = 2'd1,
      CSR_CHUNK_SIZE = 2'd2,
      CSR_CRC_POLY   = 2'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_COUNT,
      ST_LABEL,
      ST_BYTE,
      ST_CRC,
      ST_TRAIL,
      ST_FLUSH
   } state_type;

   // Which frame byte is being placed
   typedef enum logic [3:0] {
      KIND_START,
      KIND_LEN_LO,
      KIND_LEN_HI,
      KIND_ADDR_HI,
      KIND_ADDR_LO,
      KIND_DATA,
      KIND_END,
      KIND_CRC_LO,
      KIND_CRC_HI
   } kind_type;

endpackage

// ===== hw/rtl/crc_framed_chunk_builder.sv =====
// CRC-framed chunk builder: byte sequencer with a bit-serial CRC-16 and divider.
//
// A start request (tuser 0) opens a frame; each data request (tuser 1) adds one payload byte.
// Every frame byte passes through the chunk-letter slot, whether or not a letter goes out,
// and is then handed over. A byte the CRC covers is then shifted bit by bit through the
// CRC register; the two CRC bytes are not. A request is accepted in the idle state and its
// run is closed in the flush state. A start request runs the bit-serial chunk-count divider,
// places the count and then the five header bytes; a data request places its one byte. The
// request that closes a frame also goes through the end byte, the two CRC bytes and the
// trailing-label slot. The next request is taken once the previous one's last result has
// moved into the output register; stalls on the response side hold the sequence. Data
// requests with no open frame are taken and give no result. Configuration writes are always
// taken and must be made only while the block is idle.

module crc_framed_chunk_builder #(
   parameter int unsigned MAX_PAYLOAD = 56
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // payload_length[5:0], frame_address[21:6], data_byte[29:22]
   input  logic        req_tuser,   // opcode
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // frame_byte[7:0]
   output logic [1:0]  rsp_tuser,   // chunk_header[0], frame_done[1]
   output logic        rsp_tlast,   // run_last
   // Configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam logic [cfcb_pkg::LEN_W-1:0] LEN_CAP =
      (MAX_PAYLOAD > 63) ? 6'd63 : cfcb_pkg::LEN_W'(MAX_PAYLOAD);

   // Configuration registers
   logic [cfcb_pkg::BYTE_W-1:0]  start_byte_ff, start_byte_in;
   logic [cfcb_pkg::BYTE_W-1:0]  end_byte_ff, end_byte_in;
   logic [cfcb_pkg::CHUNK_W-1:0] chunk_size_ff, chunk_size_in;
   logic [cfcb_pkg::CRC_W-1:0]   crc_poly_ff, crc_poly_in;

   // Sequencer and frame state
   cfcb_pkg::state_type           state_ff, state_in;
   cfcb_pkg::kind_type            kind_ff, kind_in;
   logic                          open_ff, open_in;
   logic                          close_ff, close_in;
   logic [cfcb_pkg::LEN_W-1:0]    left_ff, left_in;
   logic [cfcb_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [cfcb_pkg::CHUNK_W-1:0]  bic_ff, bic_in;
   logic [cfcb_pkg::INDEX_W-1:0]  idx_ff, idx_in;
   logic [cfcb_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [cfcb_pkg::BYTE_W-1:0]   data_ff, data_in;
   logic [cfcb_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [cfcb_pkg::RESCNT_W-1:0] res_cnt_ff, res_cnt_in;

   // Bit-serial CRC and divider
   logic [cfcb_pkg::CRC_W-1:0]    crc_ff, crc_in;
   logic [cfcb_pkg::BYTE_W-1:0]   sh_ff, sh_in;
   logic [cfcb_pkg::TOTAL_W-1:0]  dvd_ff, dvd_in;
   logic [cfcb_pkg::TOTAL_W-1:0]  rem_ff, rem_in;
   logic [cfcb_pkg::TOTAL_W-1:0]  quo_ff, quo_in;

   // Holding stage and output register
   logic                          pend_valid_ff, pend_valid_in;
   logic [cfcb_pkg::BYTE_W-1:0]   pend_byte_ff, pend_byte_in;
   logic                          pend_hdr_ff, pend_hdr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cfcb_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                          rsp_hdr_ff, rsp_hdr_in;
   logic                          rsp_done_ff, rsp_done_in;
   logic                          rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic                          req_fire;
   logic [cfcb_pkg::LEN_W-1:0]    req_len;
   logic [cfcb_pkg::LEN_W-1:0]    len_sat;
   logic [cfcb_pkg::TOTAL_W-1:0]  eff_size;
   logic [cfcb_pkg::TOTAL_W-1:0]  bic_next;
   logic [cfcb_pkg::TOTAL_W:0]    div_trial;
   logic                          div_ge;
   logic                          crc_fb;
   logic                          label_due;
   logic [cfcb_pkg::BYTE_W-1:0]   label_byte;
   logic [cfcb_pkg::BYTE_W-1:0]   cur_byte;
   logic                          covered;
   logic                          res_full;
   logic                          out_free;
   logic                          slot_ok;
   logic                          push_req;
   logic [cfcb_pkg::BYTE_W-1:0]   push_byte;
   logic                          push_hdr;
   logic                          flush_req;
   logic                          push_go;
   logic                          push_store;
   logic                          flush_go;
   logic                          leave_byte;
   cfcb_pkg::state_type           adv_state;
   cfcb_pkg::kind_type            adv_kind;

   // Port side
   assign req_tready = (state_ff == cfcb_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_done_ff, rsp_hdr_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Request fields and payload saturation
   assign req_len = req_tdata[5:0];
   assign len_sat = (req_len > LEN_CAP) ? LEN_CAP : req_len;

   // Chunk bookkeeping
   assign eff_size   = (chunk_size_ff == '0) ? cfcb_pkg::CHUNK_MAX
                                             : {1'b0, chunk_size_ff};
   assign bic_next   = {1'b0, bic_ff} + 7'd1;
   assign label_due  = (bic_ff == '0) && (idx_ff != '0);
   assign label_byte = cfcb_pkg::LABEL_BASE + {1'b0, idx_ff};

   // One restoring-division step per cycle
   assign div_trial = {rem_ff, dvd_ff[cfcb_pkg::TOTAL_W-1]};
   assign div_ge    = (div_trial >= {1'b0, eff_size});

   // CRC feedback for the current message bit, MSB first
   assign crc_fb = crc_ff[cfcb_pkg::CRC_W-1] ^ sh_ff[cfcb_pkg::BYTE_W-1];

   // Frame byte selected by the current kind
   always_comb begin
      covered = 1'b1;
      case (kind_ff)
         cfcb_pkg::KIND_START:   cur_byte = start_byte_ff;
         cfcb_pkg::KIND_LEN_LO:  cur_byte = {1'b0, total_ff};
         cfcb_pkg::KIND_LEN_HI:  cur_byte = '0;
         cfcb_pkg::KIND_ADDR_HI: cur_byte = addr_ff[15:8];
         cfcb_pkg::KIND_ADDR_LO: cur_byte = addr_ff[7:0];
         cfcb_pkg::KIND_DATA:    cur_byte = data_ff;
         cfcb_pkg::KIND_END:     cur_byte = end_byte_ff;
         cfcb_pkg::KIND_CRC_LO: begin
            cur_byte = crc_ff[7:0];
            covered  = 1'b0;
         end
         cfcb_pkg::KIND_CRC_HI: begin
            cur_byte = crc_ff[15:8];
            covered  = 1'b0;
         end
         default:                cur_byte = '0;
      endcase
   end

   // Where the sequence goes after the current frame byte
   always_comb begin
      adv_state = cfcb_pkg::ST_LABEL;
      adv_kind  = kind_ff;
      unique case (kind_ff)
         cfcb_pkg::KIND_START:   adv_kind = cfcb_pkg::KIND_LEN_LO;
         cfcb_pkg::KIND_LEN_LO:  adv_kind = cfcb_pkg::KIND_LEN_HI;
         cfcb_pkg::KIND_LEN_HI:  adv_kind = cfcb_pkg::KIND_ADDR_HI;
         cfcb_pkg::KIND_ADDR_HI: adv_kind = cfcb_pkg::KIND_ADDR_LO;
         cfcb_pkg::KIND_ADDR_LO, cfcb_pkg::KIND_DATA: begin
            if (left_ff == '0) begin
               adv_kind = cfcb_pkg::KIND_END;
            end else begin
               adv_state = cfcb_pkg::ST_FLUSH;
            end
         end
         cfcb_pkg::KIND_END:     adv_kind = cfcb_pkg::KIND_CRC_LO;
         cfcb_pkg::KIND_CRC_LO:  adv_kind = cfcb_pkg::KIND_CRC_HI;
         cfcb_pkg::KIND_CRC_HI:  adv_state = cfcb_pkg::ST_TRAIL;
         default:                adv_state = cfcb_pkg::ST_FLUSH;
      endcase
   end

   // Holding-stage handshake
   assign res_full   = res_cnt_ff[cfcb_pkg::RESCNT_W-1];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign slot_ok    = !pend_valid_ff || out_free;
   assign push_go    = push_req && (res_full || slot_ok);
   assign push_store = push_go && !res_full;
   assign flush_go   = flush_req && slot_ok;
   assign leave_byte = (state_ff == cfcb_pkg::ST_BYTE) && push_go;

   // Sequencer outputs
   always_comb begin
      push_req  = 1'b0;
      push_byte = cur_byte;
      push_hdr  = 1'b0;
      flush_req = 1'b0;
      unique case (state_ff)
         cfcb_pkg::ST_IDLE, cfcb_pkg::ST_DIV, cfcb_pkg::ST_CRC: begin
            push_req = 1'b0;
         end
         cfcb_pkg::ST_COUNT: begin
            push_req  = 1'b1;
            push_byte = {1'b0, quo_ff} + 8'd1;
            push_hdr  = 1'b1;
         end
         cfcb_pkg::ST_LABEL, cfcb_pkg::ST_TRAIL: begin
            push_req  = label_due;
            push_byte = label_byte;
            push_hdr  = 1'b1;
         end
         cfcb_pkg::ST_BYTE: begin
            push_req = 1'b1;
         end
         cfcb_pkg::ST_FLUSH: begin
            flush_req = 1'b1;
         end
         default: begin
            push_req = 1'b0;
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cfcb_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == cfcb_pkg::OP_START) begin
                  state_in = cfcb_pkg::ST_DIV;
               end else if (open_ff) begin
                  state_in = cfcb_pkg::ST_LABEL;
               end
            end
         end
         cfcb_pkg::ST_DIV: begin
            if (step_ff == cfcb_pkg::DIV_LAST_STEP) state_in = cfcb_pkg::ST_COUNT;
         end
         cfcb_pkg::ST_COUNT: begin
            if (push_go) state_in = cfcb_pkg::ST_LABEL;
         end
         cfcb_pkg::ST_LABEL: begin
            if (!label_due || push_go) state_in = cfcb_pkg::ST_BYTE;
         end
         cfcb_pkg::ST_BYTE: begin
            if (push_go) state_in = covered ? cfcb_pkg::ST_CRC : adv_state;
         end
         cfcb_pkg::ST_CRC: begin
            if (step_ff == cfcb_pkg::CRC_LAST_STEP) state_in = adv_state;
         end
         cfcb_pkg::ST_TRAIL: begin
            if (!label_due || push_go) state_in = cfcb_pkg::ST_FLUSH;
         end
         cfcb_pkg::ST_FLUSH: begin
            if (flush_go) state_in = cfcb_pkg::ST_IDLE;
         end
         default: state_in = cfcb_pkg::ST_IDLE;
      endcase
   end

   // Datapath next values
   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      chunk_size_in = chunk_size_ff;
      crc_poly_in   = crc_poly_ff;
      kind_in       = kind_ff;
      open_in       = open_ff;
      close_in      = close_ff;
      left_in       = left_ff;
      total_in      = total_ff;
      bic_in        = bic_ff;
      idx_in        = idx_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      step_in       = step_ff;
      res_cnt_in    = res_cnt_ff;
      crc_in        = crc_ff;
      sh_in         = sh_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_hdr_in   = pend_hdr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_hdr_in    = rsp_hdr_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_last_in   = rsp_last_ff;

      // Configuration writes
      if (csr_valid) begin
         unique case (cfcb_pkg::csr_index_type'(csr_index))
            cfcb_pkg::CSR_START_BYTE: start_byte_in = csr_wdata[7:0];
            cfcb_pkg::CSR_END_BYTE:   end_byte_in   = csr_wdata[7:0];
            cfcb_pkg::CSR_CHUNK_SIZE: chunk_size_in = csr_wdata[5:0];
            cfcb_pkg::CSR_CRC_POLY:   crc_poly_in   = csr_wdata;
            default:                  crc_poly_in   = crc_poly_ff;
         endcase
      end

      // Request capture
      if (req_fire) begin
         res_cnt_in = '0;
         close_in   = 1'b0;
         data_in    = req_tdata[29:22];
         if (req_tuser == cfcb_pkg::OP_START) begin
            total_in = {1'b0, len_sat} + cfcb_pkg::FRAME_OVERHEAD;
            crc_in   = cfcb_pkg::CRC_INIT;
            bic_in   = '0;
            idx_in   = '0;
            left_in  = len_sat;
            open_in  = 1'b1;
            kind_in  = cfcb_pkg::KIND_START;
            addr_in  = req_tdata[21:6];
            dvd_in   = {1'b0, len_sat} + cfcb_pkg::FRAME_OVERHEAD;
            rem_in   = '0;
            quo_in   = '0;
            step_in  = '0;
         end else begin
            kind_in = cfcb_pkg::KIND_DATA;
         end
      end

      // Chunk count: one quotient bit per cycle
      if (state_ff == cfcb_pkg::ST_DIV) begin
         dvd_in  = {dvd_ff[cfcb_pkg::TOTAL_W-2:0], 1'b0};
         rem_in  = div_ge ? cfcb_pkg::TOTAL_W'(div_trial - {1'b0, eff_size})
                          : div_trial[cfcb_pkg::TOTAL_W-1:0];
         quo_in  = {quo_ff[cfcb_pkg::TOTAL_W-2:0], div_ge};
         step_in = step_ff + 3'd1;
      end

      // Frame byte placed: advance the chunk position
      if (leave_byte) begin
         if (bic_next >= eff_size) begin
            bic_in = '0;
            idx_in = idx_ff + 7'd1;
         end else begin
            bic_in = bic_next[cfcb_pkg::CHUNK_W-1:0];
         end
         if ((kind_ff == cfcb_pkg::KIND_DATA) && (left_ff != '0)) begin
            left_in = left_ff - 6'd1;
         end
         if (covered) begin
            sh_in   = cur_byte;
            step_in = '0;
         end else begin
            kind_in = adv_kind;
         end
      end

      // CRC: one message bit per cycle
      if (state_ff == cfcb_pkg::ST_CRC) begin
         crc_in  = {crc_ff[cfcb_pkg::CRC_W-2:0], 1'b0} ^ (crc_fb ? crc_poly_ff : '0);
         sh_in   = {sh_ff[cfcb_pkg::BYTE_W-2:0], 1'b0};
         step_in = step_ff + 3'd1;
         if (step_ff == cfcb_pkg::CRC_LAST_STEP) kind_in = adv_kind;
      end

      // Frame closes once the trailing label step is done
      if ((state_ff == cfcb_pkg::ST_TRAIL) && (!label_due || push_go)) begin
         open_in  = 1'b0;
         left_in  = '0;
         close_in = 1'b1;
      end

      // A new result moves the held one on to the output register
      if (push_store) begin
         res_cnt_in    = res_cnt_ff + 5'd1;
         pend_valid_in = 1'b1;
         pend_byte_in  = push_byte;
         pend_hdr_in   = push_hdr;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pend_byte_ff;
            rsp_hdr_in   = pend_hdr_ff;
            rsp_done_in  = 1'b0;
            rsp_last_in  = 1'b0;
         end
      end

      // End of request: the held result is the last one
      if (flush_go) begin
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_byte_in  = pend_byte_ff;
            rsp_hdr_in   = pend_hdr_ff;
            rsp_done_in  = close_ff;
            rsp_last_in  = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cfcb_pkg::ST_IDLE;
         start_byte_ff <= cfcb_pkg::START_BYTE_RST;
         end_byte_ff   <= cfcb_pkg::END_BYTE_RST;
         chunk_size_ff <= cfcb_pkg::CHUNK_SIZE_RST;
         crc_poly_ff   <= cfcb_pkg::CRC_POLY_RST;
         open_ff       <= 1'b0;
         close_ff      <= 1'b0;
         left_ff       <= '0;
         total_ff      <= '0;
         bic_ff        <= '0;
         idx_ff        <= '0;
         crc_ff        <= cfcb_pkg::CRC_INIT;
         res_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
         chunk_size_ff <= chunk_size_in;
         crc_poly_ff   <= crc_poly_in;
         open_ff       <= open_in;
         close_ff      <= close_in;
         left_ff       <= left_in;
         total_ff      <= total_in;
         bic_ff        <= bic_in;
         idx_ff        <= idx_in;
         crc_ff        <= crc_in;
         res_cnt_ff    <= res_cnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      addr_ff      <= addr_in;
      data_ff      <= data_in;
      step_ff      <= step_in;
      sh_ff        <= sh_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      pend_byte_ff <= pend_byte_in;
      pend_hdr_ff  <= pend_hdr_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_hdr_ff   <= rsp_hdr_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // A new request is only taken with nothing left in the holding stage.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("request taken while a result is still held");

   // No request yields more than sixteen results.
   a_res_limit: assert property (@(posedge clock) disable iff (reset)
      push_store |-> !res_full)
      else $error("result stored beyond the per-request limit");

   // The end of a frame is always the end of its request's run.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("frame end not marked as the last result");

   // A closed frame leaves no payload expected.
   a_close_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfcb_pkg::ST_FLUSH && close_ff) |-> (!open_ff && left_ff == '0))
      else $error("frame closed with payload still expected");

endmodule

// ===== dv/crc_framed_chunk_builder_test.sv =====
// Self-checking testbench for the CRC-framed chunk builder with a built-in frame predictor.
`timescale 1ns / 1ps

module crc_framed_chunk_builder_test;

   localparam int unsigned PAYLOAD_CAP   = 56;
   localparam int unsigned MAX_STEP_RES  = 16;
   localparam int unsigned RANDOM_ITEMS  = 150;
   localparam int unsigned IDLE_SETTLE   = 100;
   localparam int unsigned CYCLE_LIMIT   = 500000;

   // One byte of the chunked output stream and its flags.
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       chunk_header;
      logic       frame_done;
      logic       run_last;
   } stream_byte_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // payload_length[5:0], frame_address[21:6], data_byte[29:22]
   logic        req_tuser  = 1'b0; // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // frame_byte[7:0]
   logic [1:0]  rsp_tuser;         // chunk_header[0], frame_done[1]
   logic        rsp_tlast;         // run_last
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   crc_framed_chunk_builder #(
      .MAX_PAYLOAD(PAYLOAD_CAP)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror of the configuration registers.
   logic [7:0]  cfg_start = cfcb_pkg::START_BYTE_RST;
   logic [7:0]  cfg_end   = cfcb_pkg::END_BYTE_RST;
   logic [5:0]  cfg_chunk = cfcb_pkg::CHUNK_SIZE_RST;
   logic [15:0] cfg_poly  = cfcb_pkg::CRC_POLY_RST;

   // Mirror of the framing state.
   logic [15:0] crc_acc       = cfcb_pkg::CRC_INIT;
   logic [5:0]  payload_left  = '0;
   logic [6:0]  total_len     = '0;
   logic [5:0]  byte_in_chunk = '0;
   logic [6:0]  chunk_idx     = '0;
   logic        frame_open    = 1'b0;

   stream_byte_type chunk_stream_q[$];   // bytes still owed by the block, oldest first
   stream_byte_type step_bytes[$];       // bytes caused by the request being predicted

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int stall_mode     = 0;
   int stall_mode_left = 0;
   int stall_phase    = 0;

   // Appends one byte to the current request's output, dropping anything past the cap.
   function automatic void emit_byte(logic [7:0] value, logic is_header);
      stream_byte_type item;
      item.frame_byte   = value;
      item.chunk_header = is_header;
      item.frame_done   = 1'b0;
      item.run_last     = 1'b0;
      if (step_bytes.size() < MAX_STEP_RES)
         step_bytes.push_back(item);
   endfunction

   // A chunk letter goes out before the first byte of every chunk but the first.
   function automatic void emit_label_if_due();
      if (byte_in_chunk == 0 && chunk_idx != 0)
         emit_byte(cfcb_pkg::LABEL_BASE + {1'b0, chunk_idx}, 1'b1);
   endfunction

   // Register value zero stands for the largest chunk.
   function automatic logic [6:0] chunk_span();
      return (cfg_chunk == 0) ? cfcb_pkg::CHUNK_MAX : {1'b0, cfg_chunk};
   endfunction

   // MSB-first CRC-16 over one byte with the live polynomial.
   function automatic void crc_shift_in(logic [7:0] value);
      logic [15:0] acc;
      acc = crc_acc ^ {value, 8'h00};
      for (int i = 0; i < 8; i++)
         acc = acc[15] ? ((acc << 1) ^ cfg_poly) : (acc << 1);
      crc_acc = acc;
   endfunction

   // Places one frame byte, opening a new chunk when the current one is full.
   function automatic void place_frame_byte(logic [7:0] value, logic covered);
      logic [6:0] next_pos;
      emit_label_if_due();
      emit_byte(value, 1'b0);
      if (covered)
         crc_shift_in(value);
      next_pos = {1'b0, byte_in_chunk} + 7'd1;
      if (next_pos >= chunk_span()) begin
         byte_in_chunk = '0;
         chunk_idx = chunk_idx + 7'd1;
      end else begin
         byte_in_chunk = next_pos[5:0];
      end
   endfunction

   // End byte, CRC low then high, and the trailing label when the last chunk is full.
   function automatic void close_frame();
      logic [15:0] crc_sent;
      place_frame_byte(cfg_end, 1'b1);
      crc_sent = crc_acc;
      place_frame_byte(crc_sent[7:0], 1'b0);
      place_frame_byte(crc_sent[15:8], 1'b0);
      emit_label_if_due();
      if (step_bytes.size() > 0)
         step_bytes[step_bytes.size() - 1].frame_done = 1'b1;
      frame_open = 1'b0;
      payload_left = '0;
   endfunction

   // Works out the stream bytes that one accepted request causes.
   function automatic void predict_chunk_stream(cfcb_pkg::opcode_type op, logic [5:0] len,
                                                logic [15:0] addr, logic [7:0] data);
      logic [5:0] kept_len;
      logic [6:0] chunk_count;
      step_bytes.delete();
      if (op == cfcb_pkg::OP_START) begin
         kept_len = (len > PAYLOAD_CAP) ? 6'(PAYLOAD_CAP) : len;
         total_len = {1'b0, kept_len} + cfcb_pkg::FRAME_OVERHEAD;
         crc_acc = cfcb_pkg::CRC_INIT;
         byte_in_chunk = '0;
         chunk_idx = '0;
         payload_left = kept_len;
         frame_open = 1'b1;
         chunk_count = total_len / chunk_span() + 7'd1;
         emit_byte({1'b0, chunk_count}, 1'b1);
         place_frame_byte(cfg_start, 1'b1);
         place_frame_byte({1'b0, total_len}, 1'b1);
         place_frame_byte(8'h00, 1'b1);
         place_frame_byte(addr[15:8], 1'b1);
         place_frame_byte(addr[7:0], 1'b1);
         if (payload_left == 0)
            close_frame();
      end else if (frame_open) begin
         place_frame_byte(data, 1'b1);
         if (payload_left > 0)
            payload_left = payload_left - 6'd1;
         if (payload_left == 0)
            close_frame();
      end
      if (step_bytes.size() > 0)
         step_bytes[step_bytes.size() - 1].run_last = 1'b1;
      foreach (step_bytes[i])
         chunk_stream_q.push_back(step_bytes[i]);
   endfunction

   // Sends one request, in bursts separated by random gaps.
   task automatic send_request(cfcb_pkg::opcode_type op, logic [5:0] len, logic [15:0] addr,
                               logic [7:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, data, addr, len};
      do @(posedge clock); while (!req_tready);
      predict_chunk_stream(op, len, addr, data);
   endtask

   // Writes one register; bits above the register's width carry random noise.
   task automatic write_csr(cfcb_pkg::csr_index_type idx, logic [15:0] value);
      logic [15:0] noise;
      logic [15:0] wdata;
      noise = 16'($urandom);
      case (idx)
         cfcb_pkg::CSR_START_BYTE, cfcb_pkg::CSR_END_BYTE: wdata = {noise[15:8], value[7:0]};
         cfcb_pkg::CSR_CHUNK_SIZE:                         wdata = {noise[15:6], value[5:0]};
         default:                                          wdata = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cfcb_pkg::CSR_START_BYTE: cfg_start = wdata[7:0];
         cfcb_pkg::CSR_END_BYTE:   cfg_end   = wdata[7:0];
         cfcb_pkg::CSR_CHUNK_SIZE: cfg_chunk = wdata[5:0];
         default:                  cfg_poly  = wdata;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender off until every owed byte has arrived and the block has settled.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (chunk_stream_q.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Reset configuration: empty payload and a short frame with extreme data bytes.
   task automatic test_reset_defaults();
      send_request(cfcb_pkg::OP_START, 6'd0, 16'h1234, 8'hA5);
      send_request(cfcb_pkg::OP_START, 6'd2, 16'h8001, 8'h5A);
      send_request(cfcb_pkg::OP_DATA, 6'h3F, 16'hFFFF, 8'h00);
      send_request(cfcb_pkg::OP_DATA, 6'h00, 16'h0000, 8'hFF);
   endtask

   // A data request with no frame open gives nothing.
   task automatic test_stray_data();
      send_request(cfcb_pkg::OP_DATA, 6'h15, 16'hBEEF, 8'h77);
   endtask

   // An oversized length is clipped; a new start abandons the open frame.
   task automatic test_clip_and_restart();
      send_request(cfcb_pkg::OP_START, 6'h3F, 16'hFFFF, 8'hFF);
      send_request(cfcb_pkg::OP_DATA, 6'h00, 16'h0000, 8'h00);
      send_request(cfcb_pkg::OP_DATA, 6'h3F, 16'hFFFF, 8'hFF);
      send_request(cfcb_pkg::OP_START, 6'd1, 16'h0000, 8'h00);
      send_request(cfcb_pkg::OP_DATA, 6'h2A, 16'h5555, 8'hC3);
   endtask

   // Register extremes, including the one-byte chunk that overflows the result cap.
   task automatic test_register_extremes();
      wait_idle();
      write_csr(cfcb_pkg::CSR_START_BYTE, 16'h00FF);
      write_csr(cfcb_pkg::CSR_END_BYTE, 16'h0000);
      write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd1);
      write_csr(cfcb_pkg::CSR_CRC_POLY, 16'hFFFF);
      send_request(cfcb_pkg::OP_START, 6'd0, 16'hA55A, 8'h00);
      wait_idle();
      write_csr(cfcb_pkg::CSR_START_BYTE, 16'h0000);
      write_csr(cfcb_pkg::CSR_END_BYTE, 16'h00FF);
      write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd0);
      write_csr(cfcb_pkg::CSR_CRC_POLY, 16'h0000);
      send_request(cfcb_pkg::OP_START, 6'd1, 16'h0F0F, 8'h00);
      send_request(cfcb_pkg::OP_DATA, 6'd0, 16'h0000, 8'h81);
      wait_idle();
      write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd63);
      write_csr(cfcb_pkg::CSR_CRC_POLY, cfcb_pkg::CRC_POLY_RST);
      send_request(cfcb_pkg::OP_START, 6'd0, 16'hF0F0, 8'h00);
   endtask

   // Chunk size changes while a frame is still open.
   task automatic test_config_mid_frame();
      wait_idle();
      write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd19);
      send_request(cfcb_pkg::OP_START, 6'd4, 16'h4321, 8'h00);
      send_request(cfcb_pkg::OP_DATA, 6'd0, 16'h0000, 8'h11);
      send_request(cfcb_pkg::OP_DATA, 6'd0, 16'h0000, 8'h22);
      wait_idle();
      write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd2);
      send_request(cfcb_pkg::OP_DATA, 6'd0, 16'h0000, 8'h33);
      send_request(cfcb_pkg::OP_DATA, 6'd0, 16'h0000, 8'h44);
   endtask

   // Mostly complete frames with random content, some cut short, some stray data.
   task automatic test_random_traffic();
      int sent;
      int frame_len;
      int body_len;
      int kind;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         write_csr(cfcb_pkg::CSR_START_BYTE, 16'($urandom_range(0, 255)));
         write_csr(cfcb_pkg::CSR_END_BYTE, 16'($urandom_range(0, 255)));
         case ($urandom_range(0, 5))
            0:       write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd1);
            1:       write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd63);
            2:       write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'd0);
            default: write_csr(cfcb_pkg::CSR_CHUNK_SIZE, 16'($urandom_range(2, 62)));
         endcase
         case ($urandom_range(0, 5))
            0:       write_csr(cfcb_pkg::CSR_CRC_POLY, 16'h0000);
            1:       write_csr(cfcb_pkg::CSR_CRC_POLY, 16'hFFFF);
            2:       write_csr(cfcb_pkg::CSR_CRC_POLY, cfcb_pkg::CRC_POLY_RST);
            default: write_csr(cfcb_pkg::CSR_CRC_POLY, 16'($urandom));
         endcase
         repeat ($urandom_range(3, 8)) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
               // Noise: a lone data request.
               send_request(cfcb_pkg::OP_DATA, 6'($urandom), 16'($urandom), 8'($urandom));
            end else begin
               frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 63)
                                                       : $urandom_range(0, 8);
               body_len = (frame_len > PAYLOAD_CAP) ? PAYLOAD_CAP : frame_len;
               // Broken frames stop early and are abandoned by the next start.
               if (kind == 1 && body_len > 0)
                  body_len = $urandom_range(0, body_len - 1);
               send_request(cfcb_pkg::OP_START, 6'(frame_len), 16'($urandom),
                            8'($urandom));
               sent++;
               repeat (body_len) begin
                  send_request(cfcb_pkg::OP_DATA, 6'($urandom), 16'($urandom),
                               8'($urandom));
                  sent++;
               end
            end
         end
      end
   endtask

   // Receiver stalls: runs of always ready, coin-flip ready and one-in-four ready.
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_mode_left = $urandom_range(20, 200);
      end else begin
         stall_mode_left--;
      end
      stall_phase++;
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (stall_phase % 4 == 0);
      endcase
   end

   // Compares each delivered byte with the oldest owed one.
   always @(posedge clock) begin : check_results
      stream_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (chunk_stream_q.size() == 0) begin
            $error("unexpected result: frame_byte %02h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = chunk_stream_q.pop_front();
            if (rsp_tdata !== want.frame_byte) begin
               $error("frame_byte: expected %02h, got %02h", want.frame_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser[0] !== want.chunk_header) begin
               $error("chunk_header: expected %0b, got %0b", want.chunk_header,
                      rsp_tuser[0]);
               mismatch_count++;
            end
            if (rsp_tuser[1] !== want.frame_done) begin
               $error("frame_done: expected %0b, got %0b", want.frame_done, rsp_tuser[1]);
               mismatch_count++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_stray_data();
      test_clip_and_restart();
      test_register_extremes();
      test_config_mid_frame();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0 && chunk_stream_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
